@@ rtl/core/tlb_pkg.sv @@
// Shared types and constants for the page TLB block.
// No dependencies; imported by tlb_ctrl, tlb_dpath and the top level.
package tlb_pkg;

    // Parameter defaults
    localparam int TLB_DEPTH_DEF  = 64;
    localparam int COUNT_BITS_DEF = 32;

    // Register byte addresses on the config port
    localparam logic [4:0] REG_POLICY = 5'd0;
    localparam logic [4:0] REG_SHIFT  = 5'd4;
    localparam logic [4:0] REG_ENTRY  = 5'd8;
    localparam logic [4:0] REG_FLUSH  = 5'd12;
    localparam logic [4:0] REG_SKIP   = 5'd16;

    // Reset values of the registers
    localparam logic [4:0] SHIFT_RST = 5'd12;
    localparam logic [6:0] ENTRY_RST = 7'd64;

    // Replacement policies
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef struct packed {
        logic [63:0] access_address;
        logic [6:0]  access_size;
        logic        is_instruction;
    } t_in_word;

    typedef struct packed {
        logic [59:0] page_number;
        logic        was_hit;
        logic [31:0] hits_so_far;
        logic [31:0] misses_so_far;
        logic [31:0] references_so_far;
        logic        flushed_now;
        logic        last_of_access;
    } t_out_word;

    typedef struct packed {
        logic        replace_policy;
        logic [4:0]  page_shift;
        logic [6:0]  entries_in_use;
        logic [31:0] flush_period;
        logic        skip_instructions;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the incoming access
        logic lookup;    // run one page reference
        logic sel_last;  // reference the last-byte page
        logic last;      // final reference of this access
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic two_pages;
        logic out_free;
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND
    } t_state;

endpackage

@@ rtl/core/tlb_ctrl.sv @@
// TLB sequencer: takes an access, issues one or two lookups, none if skipped.
// Depends on tlb_pkg.
module tlb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_skip,
    input  tlb_pkg::t_status  i_status,
    output logic              o_stall,
    output tlb_pkg::t_cmd     o_cmd
);
    import tlb_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_stall  = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_skip) n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                if (i_status.out_free) begin
                    o_cmd.lookup = 1'b1;
                    o_cmd.last   = !i_status.two_pages;
                    n_state      = i_status.two_pages ? ST_SECOND : ST_IDLE;
                end
            end
            ST_SECOND: begin
                if (i_status.out_free) begin
                    o_cmd.lookup   = 1'b1;
                    o_cmd.sel_last = 1'b1;
                    o_cmd.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/core/tlb_dpath.sv @@
// Datapath of the page TLB: page split, ordered entry array, counters, output word.
// Depends on tlb_pkg.
module tlb_dpath #(
    parameter int TLB_DEPTH  = tlb_pkg::TLB_DEPTH_DEF,
    parameter int COUNT_BITS = tlb_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlb_pkg::t_cfg       i_cfg,
    input  tlb_pkg::t_in_word   i_word,
    input  tlb_pkg::t_cmd       i_cmd,
    input  logic                i_out_stall,
    output tlb_pkg::t_status    o_status,
    output logic                o_out_valid,
    output tlb_pkg::t_out_word  o_out_word
);
    import tlb_pkg::*;

    localparam int OW = $clog2(TLB_DEPTH + 1);

    // Captured pages of the current access
    logic [59:0] r_first, r_last;
    logic        r_two;
    logic [6:0]  size_fix;
    logic [63:0] end_addr;
    logic [63:0] first_full, last_full;

    always_comb begin
        size_fix   = (i_word.access_size == 7'd0) ? 7'd1 : i_word.access_size;
        end_addr   = i_word.access_address + 64'(size_fix) - 64'd1;
        first_full = i_word.access_address >> i_cfg.page_shift;
        last_full  = end_addr >> i_cfg.page_shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first <= first_full[59:0];
            r_last  <= last_full[59:0];
            r_two   <= (first_full[59:0] != last_full[59:0]);
        end
    end

    // Entry array, index 0 oldest
    logic [59:0]        r_entries [TLB_DEPTH];
    logic [OW-1:0]      r_occ, n_occ;
    logic [COUNT_BITS-1:0] r_hits, r_miss, r_refs, n_hits, n_miss, n_refs;
    logic [31:0]        r_cd, cd_inc;

    logic [59:0]        page;
    logic [TLB_DEPTH-1:0] match;
    logic               hit;
    logic [OW-1:0]      hit_idx;
    logic [OW-1:0]      cap;
    logic [31:0]        cap_raw;
    logic               full;
    logic               lru_hit;
    logic               miss_full;
    logic               flush;
    logic [OW-1:0]      last_pos;

    // Lookup: parallel compare against valid entries
    always_comb begin
        page = i_cmd.sel_last ? r_last : r_first;
        for (int j = 0; j < TLB_DEPTH; j++) begin
            match[j] = (OW'(j) < r_occ) && (r_entries[j] == page);
        end
    end

    // Valid entries are unique, so OR-ing indexes gives the hit position
    always_comb begin
        hit_idx = '0;
        for (int j = 0; j < TLB_DEPTH; j++) begin
            hit_idx = hit_idx | (match[j] ? OW'(j) : '0);
        end
    end

    // Replacement decisions
    always_comb begin
        hit     = |match;
        cap_raw = 32'(i_cfg.entries_in_use);
        if (cap_raw == 32'd0) cap_raw = 32'd1;
        if (cap_raw > 32'(TLB_DEPTH)) cap_raw = 32'(TLB_DEPTH);
        cap       = cap_raw[OW-1:0];
        full      = (r_occ >= cap);
        lru_hit   = hit && (i_cfg.replace_policy == POLICY_LRU);
        miss_full = !hit && full;
        last_pos  = r_occ - OW'(1);
    end

    // Per-entry update: shift toward oldest, or take the referenced page
    for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_entry
        logic sh, wr;
        always_comb begin
            sh = ((lru_hit && (OW'(g) >= hit_idx)) || miss_full) && (OW'(g) < last_pos)
                 && (r_occ != '0);
            wr = ((lru_hit || miss_full) && (OW'(g) == last_pos) && (r_occ != '0))
                 || (!hit && !full && (OW'(g) == r_occ));
        end
        if (g < TLB_DEPTH - 1) begin : g_up
            always_ff @(posedge i_clk) begin
                if (i_cmd.lookup) begin
                    if (sh) r_entries[g] <= r_entries[g+1];
                    else if (wr) r_entries[g] <= page;
                end
            end
        end else begin : g_top
            always_ff @(posedge i_clk) begin
                if (i_cmd.lookup && wr) r_entries[g] <= page;
            end
        end
    end

    // Counters and flush
    always_comb begin
        n_hits = r_hits;
        n_miss = r_miss;
        if (hit) begin
            if (r_hits != '1) n_hits = r_hits + COUNT_BITS'(1);
        end else begin
            if (r_miss != '1) n_miss = r_miss + COUNT_BITS'(1);
        end
        n_refs = (r_refs != '1) ? r_refs + COUNT_BITS'(1) : r_refs;
        cd_inc = (r_cd != '1) ? r_cd + 32'd1 : r_cd;
        flush  = (i_cfg.flush_period != 32'd0) && (cd_inc >= i_cfg.flush_period);
        n_occ  = r_occ;
        if (!hit && !full) n_occ = r_occ + OW'(1);
        if (flush) n_occ = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_hits <= '0;
            r_miss <= '0;
            r_refs <= '0;
            r_cd   <= '0;
        end else if (i_cmd.lookup) begin
            r_occ  <= n_occ;
            r_hits <= n_hits;
            r_miss <= n_miss;
            r_refs <= n_refs;
            r_cd   <= flush ? 32'd0 : cd_inc;
        end
    end

    // Output word register
    logic        r_out_valid;
    t_out_word   r_out;
    logic [63:0] hits_ext, miss_ext, refs_ext;

    always_comb begin
        hits_ext = 64'(n_hits);
        miss_ext = 64'(n_miss);
        refs_ext = 64'(n_refs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.lookup) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_out.page_number       <= page;
            r_out.was_hit           <= hit;
            r_out.hits_so_far       <= hits_ext[31:0];
            r_out.misses_so_far     <= miss_ext[31:0];
            r_out.references_so_far <= refs_ext[31:0];
            r_out.flushed_now       <= flush;
            r_out.last_of_access    <= i_cmd.last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_word         = r_out;
    assign o_status.two_pages = r_two;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

endmodule

@@ rtl/core/tlb_fifo_lru_with_flush_top.sv @@
// Top level of the page TLB: config registers, controller and datapath.
// Depends on tlb_pkg, tlb_ctrl and tlb_dpath.
//
//   channel   | signals                                  | word
//   ----------+------------------------------------------+-----------
//   access in | i_in_valid / o_in_stall / i_in_word      | t_in_word
//   result out| o_out_valid / i_out_stall / o_out_word   | t_out_word
//   config    | psel penable pwrite paddr pwdata prdata  | 32-bit regs
//
// An access is captured and then makes one page reference, or two when it
// crosses a page, or none when it is a skipped instruction; each reference is one
// compare-and-shift pass over the entry array. Results go out through a
// single output register, and a stalled result holds the next reference.
// Reset is synchronous and empties the TLB and counters at once.
module tlb_fifo_lru_with_flush_top #(
    parameter int TLB_DEPTH  = tlb_pkg::TLB_DEPTH_DEF,
    parameter int COUNT_BITS = tlb_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tlb_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tlb_pkg::t_out_word  o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tlb_pkg::*;

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic    wr_en;

    // Config registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.replace_policy    <= POLICY_FIFO;
            r_cfg.page_shift        <= SHIFT_RST;
            r_cfg.entries_in_use    <= ENTRY_RST;
            r_cfg.flush_period      <= 32'd0;
            r_cfg.skip_instructions <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr)
                REG_POLICY: r_cfg.replace_policy    <= pwdata[0];
                REG_SHIFT:  r_cfg.page_shift        <= pwdata[4:0];
                REG_ENTRY:  r_cfg.entries_in_use    <= pwdata[6:0];
                REG_FLUSH:  r_cfg.flush_period      <= pwdata;
                REG_SKIP:   r_cfg.skip_instructions <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr)
            REG_POLICY: prdata = {31'd0, r_cfg.replace_policy};
            REG_SHIFT:  prdata = {27'd0, r_cfg.page_shift};
            REG_ENTRY:  prdata = {25'd0, r_cfg.entries_in_use};
            REG_FLUSH:  prdata = r_cfg.flush_period;
            REG_SKIP:   prdata = {31'd0, r_cfg.skip_instructions};
            default:    prdata = 32'd0;
        endcase
    end

    tlb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_skip   (r_cfg.skip_instructions && i_in_word.is_instruction),
        .i_status (status),
        .o_stall  (o_in_stall),
        .o_cmd    (cmd)
    );

    tlb_dpath #(
        .TLB_DEPTH  (TLB_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_word      (i_in_word),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
